[design/gbt_pkg.sv]
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared types and constants of the graph traversal block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbt_pkg;

   localparam int NODE_W           = 4;
   localparam int FUNC_W           = 2;
   localparam int STATUS_W         = 2;
   localparam int CFG_W            = 5;
   localparam int RES_W            = 5;
   localparam int MAX_RESULTS      = 16;
   localparam int DEF_MAX_VERTICES = 16;
   localparam int DEF_MAX_DEGREE   = 16;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND = 2'd0,
      FN_CLEAR  = 2'd1,
      FN_BFS    = 2'd2,
      FN_DFS    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOP,
      S_CHECK,
      S_LOAD,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      status_type        status;
      logic              last;
   } rsp_type;

   function automatic int cnt_width(input int max_vertices);
      int w;
      w = $clog2(max_vertices + 1);
      return (w > CFG_W) ? w : CFG_W;
   endfunction

endpackage

`default_nettype wire

[design/gbt_ram.sv]
// ----------------------------------------------------------------------------
// gbt_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_ram #(
   parameter  int WIDTH = 4,
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/gbt_engine.sv]
// ----------------------------------------------------------------------------
// gbt_engine
// Sequencer for append, clear, breadth-first and depth-first runs. One list
// entry is fetched and checked at a time; the top frame is held in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_engine
   import gbt_pkg::*;
#(
   parameter  int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter  int MAX_DEGREE   = DEF_MAX_DEGREE,
   localparam int VIDX_W       = $clog2(MAX_VERTICES),
   localparam int PTR_W        = $clog2(MAX_VERTICES + 1),
   localparam int DEG_W        = $clog2(MAX_DEGREE + 1),
   localparam int ADJ_DEPTH    = MAX_VERTICES * MAX_DEGREE,
   localparam int ADJ_AW       = $clog2(ADJ_DEPTH),
   localparam int FR_W         = NODE_W + DEG_W,
   localparam int CNT_W        = cnt_width(MAX_VERTICES)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CNT_W-1:0]    live_cnt,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [NODE_W-1:0]   req_vertex,
   input  wire logic [NODE_W-1:0]   req_neighbor,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   output logic                     adj_wr_en,
   output logic      [ADJ_AW-1:0]   adj_wr_addr,
   output logic      [NODE_W-1:0]   adj_wr_data,
   output logic                     adj_rd_en,
   output logic      [ADJ_AW-1:0]   adj_rd_addr,
   input  wire logic [NODE_W-1:0]   adj_rd_data,
   output logic                     fr_wr_en,
   output logic      [VIDX_W-1:0]   fr_wr_addr,
   output logic      [FR_W-1:0]     fr_wr_data,
   output logic                     fr_rd_en,
   output logic      [VIDX_W-1:0]   fr_rd_addr,
   input  wire logic [FR_W-1:0]     fr_rd_data
);

   state_type                state_ff, state_in;
   logic [DEG_W-1:0]         deg_ff [MAX_VERTICES];
   logic [DEG_W-1:0]         deg_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]  visited_ff, visited_in;
   logic [NODE_W-1:0]        v_ff, v_in;
   logic [DEG_W-1:0]         pos_ff, pos_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [RES_W-1:0]         res_cnt_ff, res_cnt_in;
   logic                     mode_dfs_ff, mode_dfs_in;
   logic [NODE_W-1:0]        pend_node_ff, pend_node_in;
   status_type               pend_status_ff, pend_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     slot_free;
   logic                     req_v_ok;
   logic                     req_nb_ok;
   logic                     list_more;
   logic                     bfs_empty;
   logic                     dfs_bottom;
   logic                     take;
   logic                     emit;
   logic                     emit_last;
   logic [VIDX_W-1:0]        row_sel;
   logic [DEG_W-1:0]         col_sel;
   logic [ADJ_AW-1:0]        adj_addr;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_v_ok   = CNT_W'(req_vertex) < live_cnt;
   assign req_nb_ok  = CNT_W'(req_neighbor) < live_cnt;
   assign list_more  = pos_ff < deg_ff[VIDX_W'(v_ff)];
   assign bfs_empty  = head_ff == ptr_ff;
   assign dfs_bottom = ptr_ff == PTR_W'(1);
   assign take       = (CNT_W'(adj_rd_data) < live_cnt) &&
                       !visited_ff[VIDX_W'(adj_rd_data)] &&
                       (ptr_ff < PTR_W'(MAX_VERTICES)) &&
                       (res_cnt_ff < RES_W'(MAX_RESULTS));

   assign row_sel  = (state_ff == S_IDLE) ? VIDX_W'(req_vertex) : VIDX_W'(v_ff);
   assign col_sel  = (state_ff == S_IDLE) ? deg_ff[VIDX_W'(req_vertex)] : pos_ff;
   assign adj_addr = ADJ_AW'(row_sel) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(col_sel);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if ((req_func == FN_BFS || req_func == FN_DFS) && req_v_ok) begin
                  state_in = S_TOP;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_TOP: begin
            if (list_more) begin
               state_in = S_CHECK;
            end else if (mode_dfs_ff ? dfs_bottom : bfs_empty) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_CHECK: begin
            if (!take || slot_free) begin
               state_in = S_TOP;
            end
         end
         S_LOAD: begin
            state_in = S_TOP;
         end
         S_FLUSH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      deg_in         = deg_ff;
      visited_in     = visited_ff;
      v_in           = v_ff;
      pos_in         = pos_ff;
      ptr_in         = ptr_ff;
      head_in        = head_ff;
      res_cnt_in     = res_cnt_ff;
      mode_dfs_in    = mode_dfs_ff;
      pend_node_in   = pend_node_ff;
      pend_status_in = pend_status_ff;
      adj_wr_en      = 1'b0;
      adj_wr_addr    = adj_addr;
      adj_wr_data    = req_neighbor;
      adj_rd_en      = 1'b0;
      adj_rd_addr    = adj_addr;
      fr_wr_en       = 1'b0;
      fr_wr_addr     = VIDX_W'(ptr_ff);
      fr_wr_data     = {adj_rd_data, DEG_W'(0)};
      fr_rd_en       = 1'b0;
      fr_rd_addr     = VIDX_W'(head_ff);
      emit           = 1'b0;
      emit_last      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pend_node_in   = '0;
               pend_status_in = ST_OK;
               unique case (req_func)
                  FN_APPEND: begin
                     if (!(req_v_ok && req_nb_ok)) begin
                        pend_status_in = ST_RANGE;
                     end else if (col_sel >= DEG_W'(MAX_DEGREE)) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        adj_wr_en = 1'b1;
                        deg_in[row_sel] = DEG_W'(col_sel + 1'b1);
                     end
                  end
                  FN_CLEAR: begin
                     deg_in = '{default: '0};
                  end
                  FN_BFS, FN_DFS: begin
                     if (!req_v_ok) begin
                        pend_status_in = ST_RANGE;
                     end else begin
                        visited_in          = '0;
                        visited_in[row_sel] = 1'b1;
                        pend_node_in        = req_vertex;
                        v_in                = req_vertex;
                        pos_in              = '0;
                        ptr_in              = PTR_W'(1);
                        head_in             = PTR_W'(1);
                        res_cnt_in          = RES_W'(1);
                        mode_dfs_in         = (req_func == FN_DFS);
                     end
                  end
                  default: begin
                     pend_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_TOP: begin
            if (list_more) begin
               adj_rd_en = 1'b1;
               pos_in    = DEG_W'(pos_ff + 1'b1);
            end else if (!mode_dfs_ff && !bfs_empty) begin
               fr_rd_en   = 1'b1;
               fr_rd_addr = VIDX_W'(head_ff);
               head_in    = PTR_W'(head_ff + 1'b1);
            end else if (mode_dfs_ff && !dfs_bottom) begin
               fr_rd_en   = 1'b1;
               fr_rd_addr = VIDX_W'(ptr_ff - PTR_W'(2));
               ptr_in     = PTR_W'(ptr_ff - 1'b1);
            end
         end
         S_CHECK: begin
            if (take && slot_free) begin
               emit                                = 1'b1;
               pend_node_in                        = adj_rd_data;
               visited_in[VIDX_W'(adj_rd_data)]    = 1'b1;
               res_cnt_in                          = RES_W'(res_cnt_ff + 1'b1);
               ptr_in                              = PTR_W'(ptr_ff + 1'b1);
               fr_wr_en                            = 1'b1;
               if (mode_dfs_ff) begin
                  fr_wr_addr = VIDX_W'(ptr_ff - 1'b1);
                  fr_wr_data = {v_ff, pos_ff};
                  v_in       = adj_rd_data;
                  pos_in     = '0;
               end else begin
                  fr_wr_addr = VIDX_W'(ptr_ff);
                  fr_wr_data = {adj_rd_data, DEG_W'(0)};
               end
            end
         end
         S_LOAD: begin
            v_in   = fr_rd_data[FR_W-1 -: NODE_W];
            pos_in = fr_rd_data[DEG_W-1:0];
         end
         S_FLUSH: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.node   = pend_node_ff;
         rsp_data_in.status = pend_status_ff;
         rsp_data_in.last   = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         deg_ff       <= '{default: '0};
         visited_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         deg_ff       <= deg_in;
         visited_ff   <= visited_in;
      end
      v_ff           <= v_in;
      pos_ff         <= pos_in;
      ptr_ff         <= ptr_in;
      head_ff        <= head_in;
      res_cnt_ff     <= res_cnt_in;
      mode_dfs_ff    <= mode_dfs_in;
      pend_node_ff   <= pend_node_in;
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[design/graph_bfs_dfs_traversal_top.sv]
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_top
// Directed graph store with breadth-first and depth-first traversal.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_func, req_vertex, req_neighbor
//   rsp       out         rsp_valid / rsp_ready   rsp_node, rsp_status, rsp_last
//   csr       in          csr_wr_en               csr_wr_data (vertex count)
//
// Append, clear and rejected words pass from the idle state through the flush
// state to the response register. Traversals scan each list entry through the
// top and check states, and dequeue a vertex or pop a frame through the top
// and load states. A full response register stalls the scan until the word is taken.
// Reset clears the lists' lengths and the visited marks at once.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_dfs_traversal_top
   import gbt_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_DEGREE   = DEF_MAX_DEGREE
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [NODE_W-1:0]   req_vertex,
   input  wire logic [NODE_W-1:0]   req_neighbor,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [NODE_W-1:0]   rsp_node,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic                     rsp_last,
   input  wire logic                csr_wr_en,
   input  wire logic [CFG_W-1:0]    csr_wr_data
);

   localparam int VIDX_W    = $clog2(MAX_VERTICES);
   localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
   localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;
   localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
   localparam int FR_W      = NODE_W + DEG_W;
   localparam int CNT_W     = cnt_width(MAX_VERTICES);

   logic [CFG_W-1:0]  vertex_count_ff, vertex_count_in;
   logic [CNT_W-1:0]  live_cnt;
   rsp_type           rsp_data;

   logic              adj_wr_en;
   logic [ADJ_AW-1:0] adj_wr_addr;
   logic [NODE_W-1:0] adj_wr_data;
   logic              adj_rd_en;
   logic [ADJ_AW-1:0] adj_rd_addr;
   logic [NODE_W-1:0] adj_rd_data;
   logic              fr_wr_en;
   logic [VIDX_W-1:0] fr_wr_addr;
   logic [FR_W-1:0]   fr_wr_data;
   logic              fr_rd_en;
   logic [VIDX_W-1:0] fr_rd_addr;
   logic [FR_W-1:0]   fr_rd_data;

   assign vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= CFG_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign live_cnt = (CNT_W'(vertex_count_ff) < CNT_W'(MAX_VERTICES)) ?
                     CNT_W'(vertex_count_ff) : CNT_W'(MAX_VERTICES);

   gbt_engine #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .live_cnt     (live_cnt),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_vertex   (req_vertex),
      .req_neighbor (req_neighbor),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .adj_wr_en    (adj_wr_en),
      .adj_wr_addr  (adj_wr_addr),
      .adj_wr_data  (adj_wr_data),
      .adj_rd_en    (adj_rd_en),
      .adj_rd_addr  (adj_rd_addr),
      .adj_rd_data  (adj_rd_data),
      .fr_wr_en     (fr_wr_en),
      .fr_wr_addr   (fr_wr_addr),
      .fr_wr_data   (fr_wr_data),
      .fr_rd_en     (fr_rd_en),
      .fr_rd_addr   (fr_rd_addr),
      .fr_rd_data   (fr_rd_data)
   );

   gbt_ram #(
      .WIDTH (NODE_W),
      .DEPTH (ADJ_DEPTH)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   gbt_ram #(
      .WIDTH (FR_W),
      .DEPTH (MAX_VERTICES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_wr_en),
      .wr_addr (fr_wr_addr),
      .wr_data (fr_wr_data),
      .rd_en   (fr_rd_en),
      .rd_addr (fr_rd_addr),
      .rd_data (fr_rd_data)
   );

   assign rsp_node   = rsp_data.node;
   assign rsp_status = rsp_data.status;
   assign rsp_last   = rsp_data.last;

endmodule

`default_nettype wire

[design/gbt_checker.sv]
// ----------------------------------------------------------------------------
// gbt_checker
// Port-level checks of the graph traversal block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_checker
   import gbt_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [NODE_W-1:0]   rsp_node,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_last
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_node) && $stable(rsp_status) && $stable(rsp_last))
      else $error("response word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in progress");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_node == '0)
      else $error("error status on a non-final or nonzero word");

   a_idle_final: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("ready while a non-final word waits");

endmodule

bind graph_bfs_dfs_traversal_top gbt_checker u_checker (.*);

`default_nettype wire

[test/graph_bfs_dfs_traversal_top_test.sv]
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_top_test
// Self-checking bench for the graph traversal block. A scoreboard keeps its
// own copy of the adjacency lists and the vertex count, works out the visit
// order of every accepted word and checks each result word in order. The
// stimulus is a directed pass over the special cases followed by random
// graph builds, full lists, long chains and noise under several counts,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_top_test
   import gbt_pkg::*;
();

   class traversal_scoreboard;
      logic [NODE_W-1:0] adjacency [DEF_MAX_VERTICES][DEF_MAX_DEGREE];
      int                degree [DEF_MAX_VERTICES];
      bit                visited [DEF_MAX_VERTICES];
      logic [CFG_W-1:0]  vertex_limit;
      rsp_type           expected_words[$];
      rsp_type           batch[$];
      int                errors;

      function new();
         foreach (degree[i]) degree[i] = 0;
         foreach (visited[i]) visited[i] = 1'b0;
         vertex_limit = CFG_RESET;
         errors = 0;
      endfunction

      function int live_vertices();
         return (vertex_limit < DEF_MAX_VERTICES) ? int'(vertex_limit) : DEF_MAX_VERTICES;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void emit(int node, status_type st);
         rsp_type w;
         w.node   = node[NODE_W-1:0];
         w.status = st;
         w.last   = 1'b0;
         batch.insert(batch.size(), w);
      endfunction

      function void breadth_walk(int start, int cnt);
         int fifo [DEF_MAX_VERTICES];
         int head;
         int tail;
         int v;
         int w;
         int i;
         head = 0;
         tail = 0;
         foreach (visited[j]) visited[j] = 1'b0;
         visited[start] = 1'b1;
         fifo[tail] = start;
         tail++;
         emit(start, ST_OK);
         while (head < tail) begin
            v = fifo[head];
            head++;
            for (i = 0; i < degree[v]; i++) begin
               w = adjacency[v][i];
               if (w < cnt && !visited[w] && tail < DEF_MAX_VERTICES
                     && batch.size() < MAX_RESULTS) begin
                  visited[w] = 1'b1;
                  fifo[tail] = w;
                  tail++;
                  emit(w, ST_OK);
               end
            end
         end
      endfunction

      function void depth_walk(int start, int cnt);
         int frame_vtx [DEF_MAX_VERTICES];
         int frame_pos [DEF_MAX_VERTICES];
         int sp;
         int v;
         int p;
         int w;
         foreach (visited[j]) visited[j] = 1'b0;
         visited[start] = 1'b1;
         frame_vtx[0] = start;
         frame_pos[0] = 0;
         sp = 1;
         emit(start, ST_OK);
         while (sp > 0) begin
            v = frame_vtx[sp-1];
            p = frame_pos[sp-1];
            if (p < degree[v]) begin
               w = adjacency[v][p];
               frame_pos[sp-1] = p + 1;
               if (w < cnt && !visited[w] && sp < DEF_MAX_VERTICES
                     && batch.size() < MAX_RESULTS) begin
                  visited[w] = 1'b1;
                  frame_vtx[sp] = w;
                  frame_pos[sp] = 0;
                  sp++;
                  emit(w, ST_OK);
               end
            end else begin
               sp--;
            end
         end
      endfunction

      function void note_word(func_type f, logic [NODE_W-1:0] vtx, logic [NODE_W-1:0] nbr);
         int cnt;
         cnt = live_vertices();
         batch.delete();
         case (f)
            FN_APPEND: begin
               if (vtx >= cnt || nbr >= cnt) begin
                  emit(0, ST_RANGE);
               end else if (degree[vtx] >= DEF_MAX_DEGREE) begin
                  emit(0, ST_FULL);
               end else begin
                  adjacency[vtx][degree[vtx]] = nbr;
                  degree[vtx]++;
                  emit(0, ST_OK);
               end
            end
            FN_CLEAR: begin
               foreach (degree[i]) degree[i] = 0;
               emit(0, ST_OK);
            end
            default: begin
               if (vtx >= cnt) emit(0, ST_RANGE);
               else if (f == FN_BFS) breadth_walk(vtx, cnt);
               else depth_walk(vtx, cnt);
            end
         endcase
         batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) expected_words.insert(expected_words.size(), batch[i]);
      endfunction

      function void check_word(logic [NODE_W-1:0] node, logic [STATUS_W-1:0] status,
                               logic last);
         rsp_type exp_word;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: node %0d status %0d last %0d", node, status, last);
            errors++;
            return;
         end
         exp_word = expected_words.pop_front();
         if (node !== exp_word.node) begin
            $error("node mismatch: expected %0d, actual %0d", exp_word.node, node);
            errors++;
         end
         if (status !== exp_word.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_word.status, status);
            errors++;
         end
         if (last !== exp_word.last) begin
            $error("last mismatch: expected %0d, actual %0d", exp_word.last, last);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 5000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func;
   logic [NODE_W-1:0]   req_vertex;
   logic [NODE_W-1:0]   req_neighbor;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [NODE_W-1:0]   rsp_node;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   logic                csr_wr_en;
   logic [CFG_W-1:0]    csr_wr_data;

   traversal_scoreboard sb;
   int                  gap_pct;
   int                  stall_pct;
   int                  words_sent;
   int                  idle_cycles;

   graph_bfs_dfs_traversal_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_vertex   (req_vertex),
      .req_neighbor (req_neighbor),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_node     (rsp_node),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_word(rsp_node, rsp_status, rsp_last);
         if (req_valid && req_ready)
            sb.note_word(func_type'(req_func), req_vertex, req_neighbor);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stall the result channel in random bursts
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(func_type f, logic [NODE_W-1:0] vtx, logic [NODE_W-1:0] nbr);
      if ($urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_func     <= f;
      req_vertex   <= vtx;
      req_neighbor <= nbr;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_vertex_count(logic [CFG_W-1:0] count);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      sb.vertex_limit = count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [NODE_W-1:0] pick_vertex();
      int cnt;
      cnt = sb.live_vertices();
      if (cnt > 0 && $urandom_range(0, 9) != 0) return NODE_W'($urandom_range(0, cnt - 1));
      return NODE_W'($urandom_range(0, 15));
   endfunction

   function automatic func_type pick_walk();
      return $urandom_range(0, 1) ? FN_BFS : FN_DFS;
   endfunction

   task automatic directed_checks();
      // empty graph, then a small graph with a self loop
      send_word(FN_DFS, 4'd5, 4'd0);
      send_word(FN_BFS, 4'd15, 4'd15);
      send_word(FN_APPEND, 4'd0, 4'd15);
      send_word(FN_APPEND, 4'd15, 4'd0);
      send_word(FN_APPEND, 4'd15, 4'd15);
      send_word(FN_APPEND, 4'd0, 4'd7);
      send_word(FN_APPEND, 4'd7, 4'd3);
      send_word(FN_APPEND, 4'd0, 4'd3);
      send_word(FN_BFS, 4'd0, 4'd0);
      send_word(FN_DFS, 4'd0, 4'd0);
      send_word(FN_DFS, 4'd15, 4'd0);
      // lower the count: range errors and stale neighbors
      set_vertex_count(5'd4);
      send_word(FN_APPEND, 4'd5, 4'd1);
      send_word(FN_APPEND, 4'd1, 4'd9);
      send_word(FN_APPEND, 4'd0, 4'd1);
      send_word(FN_BFS, 4'd9, 4'd0);
      send_word(FN_DFS, 4'd4, 4'd0);
      send_word(FN_DFS, 4'd0, 4'd0);
      send_word(FN_BFS, 4'd0, 4'd0);
      send_word(FN_CLEAR, 4'd0, 4'd0);
      // zero count rejects every vertex
      set_vertex_count(5'd0);
      send_word(FN_APPEND, 4'd0, 4'd0);
      send_word(FN_BFS, 4'd0, 4'd0);
      send_word(FN_DFS, 4'd0, 4'd0);
      send_word(FN_CLEAR, 4'd15, 4'd15);
   endtask

   task automatic random_traffic(int words);
      int start;
      int kind;
      int cnt;
      logic [NODE_W-1:0] owner;
      start = words_sent;
      while (words_sent - start < words) begin
         kind = $urandom_range(0, 9);
         cnt  = sb.live_vertices();
         if (kind <= 3) begin
            if ($urandom_range(0, 1)) send_word(FN_CLEAR, pick_vertex(), pick_vertex());
            repeat ($urandom_range(2, 12)) send_word(FN_APPEND, pick_vertex(), pick_vertex());
            repeat ($urandom_range(2, 4)) send_word(pick_walk(), pick_vertex(), pick_vertex());
         end else if (kind == 4) begin
            // overfill one list
            owner = pick_vertex();
            repeat (17) send_word(FN_APPEND, owner, pick_vertex());
            send_word(pick_walk(), owner, pick_vertex());
         end else if (kind == 5 && cnt > 1) begin
            // long chain for deep stacks and full result bursts
            send_word(FN_CLEAR, pick_vertex(), pick_vertex());
            for (int i = 0; i < cnt - 1; i++) send_word(FN_APPEND, NODE_W'(i), NODE_W'(i + 1));
            repeat (3) send_word(FN_APPEND, pick_vertex(), pick_vertex());
            send_word(FN_DFS, 4'd0, pick_vertex());
            send_word(FN_BFS, 4'd0, pick_vertex());
            send_word(pick_walk(), pick_vertex(), pick_vertex());
         end else if (kind == 9) begin
            drain_results();
         end else begin
            repeat ($urandom_range(1, 4))
               send_word(func_type'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 15)),
                         NODE_W'($urandom_range(0, 15)));
         end
      end
   endtask

   initial begin
      req_valid    = 1'b0;
      req_func     = FN_APPEND;
      req_vertex   = '0;
      req_neighbor = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      words_sent   = 0;
      gap_pct      = 30;
      stall_pct    = 30;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_checks();

      set_vertex_count(5'd31);
      random_traffic(45);
      gap_pct   = 0;
      stall_pct = 50;
      set_vertex_count(5'd1);
      random_traffic(15);
      gap_pct   = 50;
      stall_pct = 0;
      set_vertex_count(5'd17);
      random_traffic(30);
      gap_pct   = 25;
      stall_pct = 25;
      set_vertex_count(CFG_W'($urandom_range(2, 15)));
      random_traffic(45);
      gap_pct   = 0;
      stall_pct = 0;
      set_vertex_count(5'd16);
      random_traffic(55);

      drain_results();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
